FILE: design/dtes_pkg.sv
`default_nettype none
package dtes_pkg;

   localparam int YEAR_W  = 12;
   localparam int MONTH_W = 4;
   localparam int DAY_W   = 5;
   localparam int HOUR_W  = 5;
   localparam int MIN_W   = 6;
   localparam int SEC_W   = 6;
   localparam int EPOCH_W = 32;

   // days since the epoch stay below 2^16 over the supported years
   localparam int DAYS_W  = 16;
   // hour*3600 + minute*60 + second for any input bit pattern
   localparam int HMS_W   = 17;

   localparam logic [YEAR_W-1:0]  EPOCH_YEAR    = 12'd1970;
   localparam logic [YEAR_W-1:0]  LAST_YEAR     = 12'd2099;
   localparam logic [MONTH_W-1:0] MONTH_FIRST   = 4'd1;
   localparam logic [MONTH_W-1:0] MONTH_LAST    = 4'd12;
   localparam logic [MONTH_W-1:0] MONTH_FEB     = 4'd2;
   localparam logic [8:0]         DAYS_YEAR     = 9'd365;
   localparam logic [16:0]        SECS_DAY      = 17'd86400;
   localparam logic [11:0]        SECS_HOUR     = 12'd3600;
   localparam logic [5:0]         SECS_MINUTE   = 6'd60;

   // result of the calendar stages, handed to the seconds stages
   typedef struct packed {
      logic              valid;
      logic              err;
      logic [DAYS_W-1:0] days;
      logic [HMS_W-1:0]  hms;
   } cal_out_type;

   // days before the first of a month in a common year; index 0 is January
   function automatic logic [8:0] month_start(input logic [MONTH_W-1:0] idx);
      logic [8:0] d;
      begin
         case (idx)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd59;
            4'd3:    d = 9'd90;
            4'd4:    d = 9'd120;
            4'd5:    d = 9'd151;
            4'd6:    d = 9'd181;
            4'd7:    d = 9'd212;
            4'd8:    d = 9'd243;
            4'd9:    d = 9'd273;
            4'd10:   d = 9'd304;
            4'd11:   d = 9'd334;
            default: d = 9'd0;
         endcase
         return d;
      end
   endfunction

endpackage
`default_nettype wire

FILE: design/dtes_calendar.sv
`default_nettype none
module dtes_calendar (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           advance,
   input  wire logic                           in_valid,
   input  wire logic [dtes_pkg::YEAR_W-1:0]    year,
   input  wire logic [dtes_pkg::MONTH_W-1:0]   month,
   input  wire logic [dtes_pkg::DAY_W-1:0]     day,
   input  wire logic [dtes_pkg::HOUR_W-1:0]    hour,
   input  wire logic [dtes_pkg::MIN_W-1:0]     minute,
   input  wire logic [dtes_pkg::SEC_W-1:0]     second,
   output dtes_pkg::cal_out_type               cal_out
);
   import dtes_pkg::*;

   // stage 1: range check, year offset, clamp month, time products
   logic               v1_ff;
   logic               err1_ff, err1_in;
   logic [7:0]         n1_ff, n1_in;
   logic               leap1_ff, leap1_in;
   logic [MONTH_W-1:0] mon1_ff, mon1_in;
   logic [DAY_W-1:0]   day1_ff;
   logic [HMS_W-1:0]   hsec1_ff, hsec1_in;
   logic [11:0]        msec1_ff, msec1_in;
   logic [SEC_W-1:0]   sec1_ff;

   // stage 2: days of whole years and whole months, time of day
   logic               v2_ff;
   logic               err2_ff;
   logic [DAYS_W-1:0]  yd2_ff, yd2_in;
   logic [8:0]         md2_ff, md2_in;
   logic [DAY_W-1:0]   day2_ff;
   logic [HMS_W-1:0]   hms2_ff, hms2_in;

   // stage 3: day count
   logic               v3_ff;
   logic               err3_ff;
   logic [DAYS_W-1:0]  days3_ff, days3_in;
   logic [HMS_W-1:0]   hms3_ff;

   always_comb begin
      logic [YEAR_W-1:0] diff;
      err1_in = (year < EPOCH_YEAR) || (year > LAST_YEAR);
      diff    = year - EPOCH_YEAR;
      n1_in   = diff[7:0];
      // within 1970..2099 the only century is 2000, a leap year
      leap1_in = (year[1:0] == 2'b00);
      if (month < MONTH_FIRST) begin
         mon1_in = MONTH_FIRST;
      end else if (month > MONTH_LAST) begin
         mon1_in = MONTH_LAST;
      end else begin
         mon1_in = month;
      end
      hsec1_in = HMS_W'({12'd0, hour} * {5'd0, SECS_HOUR});
      msec1_in = 12'({6'd0, minute} * {6'd0, SECS_MINUTE});
   end

   always_comb begin
      logic [8:0] n_ext;
      logic [5:0] leaps;
      n_ext  = {1'b0, n1_ff} + 9'd1;
      // leap years in [1970, year) are 1972, 1976, ...
      leaps  = n_ext[7:2];
      yd2_in = DAYS_W'({8'd0, n1_ff} * {7'd0, DAYS_YEAR}) + DAYS_W'(leaps);
      md2_in = month_start(mon1_ff - MONTH_FIRST)
             + {8'd0, (leap1_ff && (mon1_ff > MONTH_FEB))};
      hms2_in = hsec1_ff + HMS_W'(msec1_ff) + HMS_W'(sec1_ff);
   end

   assign days3_in = yd2_ff + DAYS_W'(md2_ff) + DAYS_W'(day2_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         err1_ff  <= err1_in;
         n1_ff    <= n1_in;
         leap1_ff <= leap1_in;
         mon1_ff  <= mon1_in;
         day1_ff  <= day;
         hsec1_ff <= hsec1_in;
         msec1_ff <= msec1_in;
         sec1_ff  <= second;

         err2_ff  <= err1_ff;
         yd2_ff   <= yd2_in;
         md2_ff   <= md2_in;
         day2_ff  <= day1_ff;
         hms2_ff  <= hms2_in;

         err3_ff  <= err2_ff;
         days3_ff <= days3_in;
         hms3_ff  <= hms2_ff;
      end
   end

   assign cal_out.valid = v3_ff;
   assign cal_out.err   = err3_ff;
   assign cal_out.days  = days3_ff;
   assign cal_out.hms   = hms3_ff;

endmodule
`default_nettype wire

FILE: design/date_to_epoch_seconds.sv
// Calendar date and time to seconds since 1970-01-01 00:00:00.
//
// Request channel: req_valid with req_year, req_month, req_day, req_hour,
// req_minute, req_second; a request is taken on a clock edge with
// req_valid high and req_stall low.
// Response channel: rsp_valid with rsp_epoch_seconds and rsp_status;
// status 1 flags a year outside 1970..2099 and comes with a zero count.
// Month is clamped to 1..12; day, hour, minute and second are added as
// given and the sum wraps modulo 2^32.
//
// Requests pass through a five-stage pipeline (range check, year/month
// day counts, day sum, day*86400 multiply, final add). A new request
// can enter every cycle while req_stall is low.
// While rsp_valid is high and rsp_stall is asserted the whole pipeline
// holds and req_stall is raised; nothing is dropped or repeated.
// Reset (synchronous, active high) empties the pipeline.
`default_nettype none
module date_to_epoch_seconds (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output      logic                            req_stall,
   input  wire logic [dtes_pkg::YEAR_W-1:0]     req_year,
   input  wire logic [dtes_pkg::MONTH_W-1:0]    req_month,
   input  wire logic [dtes_pkg::DAY_W-1:0]      req_day,
   input  wire logic [dtes_pkg::HOUR_W-1:0]     req_hour,
   input  wire logic [dtes_pkg::MIN_W-1:0]      req_minute,
   input  wire logic [dtes_pkg::SEC_W-1:0]      req_second,
   output      logic                            rsp_valid,
   input  wire logic                            rsp_stall,
   output      logic [dtes_pkg::EPOCH_W-1:0]    rsp_epoch_seconds,
   output      logic                            rsp_status
);
   import dtes_pkg::*;

   logic                advance;
   cal_out_type         cal;

   logic                v4_ff;
   logic                err4_ff;
   logic [EPOCH_W-1:0]  prod4_ff, prod4_in;
   logic [HMS_W-1:0]    hms4_ff;

   logic                rsp_valid_ff;
   logic [EPOCH_W-1:0]  epoch_ff, epoch_in;
   logic                status_ff;

   // hold every stage while a response waits on a stalled receiver
   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !advance;

   dtes_calendar u_calendar (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_valid (req_valid),
      .year     (req_year),
      .month    (req_month),
      .day      (req_day),
      .hour     (req_hour),
      .minute   (req_minute),
      .second   (req_second),
      .cal_out  (cal)
   );

   assign prod4_in = EPOCH_W'({17'd0, cal.days} * {16'd0, SECS_DAY});

   // days counted from day 1, so drop one day; wraps when day is zero
   assign epoch_in = err4_ff ? '0
                   : (prod4_ff - EPOCH_W'(SECS_DAY) + EPOCH_W'(hms4_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         v4_ff        <= cal.valid;
         rsp_valid_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         err4_ff   <= cal.err;
         prod4_ff  <= prod4_in;
         hms4_ff   <= cal.hms;
         epoch_ff  <= epoch_in;
         status_ff <= err4_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_epoch_seconds = epoch_ff;
   assign rsp_status        = status_ff;

endmodule
`default_nettype wire

FILE: sim/date_to_epoch_seconds_tb.sv
module date_to_epoch_seconds_tb;
   import dtes_pkg::*;

   localparam bit [31:0]   LEAP_YEAR_SECS    = 32'd31622400;
   localparam bit [31:0]   COMMON_YEAR_SECS  = 32'd31536000;
   localparam bit [31:0]   DAY_SECS          = 32'd86400;
   localparam bit [31:0]   HOUR_SECS         = 32'd3600;
   localparam bit [31:0]   MINUTE_SECS       = 32'd60;
   localparam int          MONTH_DAYS [12]   = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
   localparam bit          STATUS_OK         = 1'b0;
   localparam bit          STATUS_YEAR_RANGE = 1'b1;
   localparam int unsigned MAX_REPORTS       = 10;
   localparam int unsigned QUIET_LIMIT       = 1000;
   localparam int unsigned SINK_HOLD_CYCLES  = 120;
   localparam int unsigned DRAIN_CYCLES      = 12;

   typedef struct packed {
      logic [YEAR_W-1:0]  year;
      logic [MONTH_W-1:0] month;
      logic [DAY_W-1:0]   day;
      logic [HOUR_W-1:0]  hour;
      logic [MIN_W-1:0]   minute;
      logic [SEC_W-1:0]   second;
   } date_req_type;

   typedef struct packed {
      logic [EPOCH_W-1:0] secs;
      logic               status;
   } epoch_rsp_type;

   logic                clock       = 1'b0;
   logic                reset       = 1'b1;
   logic                req_valid   = 1'b0;
   logic                req_stall;
   logic [YEAR_W-1:0]   req_year    = '0;
   logic [MONTH_W-1:0]  req_month   = '0;
   logic [DAY_W-1:0]    req_day     = '0;
   logic [HOUR_W-1:0]   req_hour    = '0;
   logic [MIN_W-1:0]    req_minute  = '0;
   logic [SEC_W-1:0]    req_second  = '0;
   logic                rsp_valid;
   logic                rsp_stall   = 1'b0;
   logic [EPOCH_W-1:0]  rsp_epoch_seconds;
   logic                rsp_status;

   epoch_rsp_type epoch_queue [$];
   int unsigned error_count        = 0;
   int unsigned req_count          = 0;
   int unsigned rsp_count          = 0;
   int unsigned range_error_count  = 0;
   int unsigned input_stall_cycles = 0;
   int unsigned hold_count         = 0;
   bit          source_gaps_on     = 1'b1;
   bit          sink_stalls_on     = 1'b1;
   bit          sink_hold_req      = 1'b0;
   bit          sink_holding       = 1'b0;

   date_to_epoch_seconds u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_year          (req_year),
      .req_month         (req_month),
      .req_day           (req_day),
      .req_hour          (req_hour),
      .req_minute        (req_minute),
      .req_second        (req_second),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_epoch_seconds (rsp_epoch_seconds),
      .rsp_status        (rsp_status)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic bit year_is_leap(input int unsigned y);
      if (y % 4 != 0) return 1'b0;
      if (y % 100 != 0) return 1'b1;
      return (y % 400) == 0;
   endfunction

   function automatic epoch_rsp_type calendar_to_epoch(input date_req_type d);
      epoch_rsp_type r;
      bit [31:0]   secs;
      int unsigned mon;
      bit          leap;
      r.status = STATUS_OK;
      secs = '0;
      if (d.year < EPOCH_YEAR || d.year > LAST_YEAR) begin
         r.secs = '0;
         r.status = STATUS_YEAR_RANGE;
         return r;
      end
      mon = d.month;
      if (mon < MONTH_FIRST) mon = MONTH_FIRST;
      if (mon > MONTH_LAST) mon = MONTH_LAST;
      for (int unsigned y = EPOCH_YEAR; y < d.year; y++) begin
         secs += year_is_leap(y) ? LEAP_YEAR_SECS : COMMON_YEAR_SECS;
      end
      leap = year_is_leap(d.year);
      for (int unsigned m = 1; m < mon; m++) begin
         secs += 32'(MONTH_DAYS[m-1]) * DAY_SECS;
         if (leap && m == MONTH_FEB) secs += DAY_SECS;
      end
      // day zero wraps: (0 - 1) * 86400 modulo 2^32
      secs += (32'(d.day) - 32'd1) * DAY_SECS;
      secs += 32'(d.hour) * HOUR_SECS;
      secs += 32'(d.minute) * MINUTE_SECS;
      secs += 32'(d.second);
      r.secs = secs;
      return r;
   endfunction

   function automatic date_req_type random_date(input bit wild_year, input bit wild_fields);
      date_req_type d;
      if (!wild_year) begin
         d.year = YEAR_W'($urandom_range(EPOCH_YEAR, LAST_YEAR));
      end else if ($urandom_range(0, 3) == 0) begin
         // stay close to the range limits
         d.year = ($urandom_range(0, 1) == 0) ? YEAR_W'($urandom_range(1966, 1973))
                                               : YEAR_W'($urandom_range(2096, 2103));
      end else begin
         d.year = YEAR_W'($urandom_range(0, 4095));
      end
      if (wild_fields) begin
         d.month  = MONTH_W'($urandom_range(0, 15));
         d.day    = DAY_W'($urandom_range(0, 31));
         d.hour   = HOUR_W'($urandom_range(0, 31));
         d.minute = MIN_W'($urandom_range(0, 63));
         d.second = SEC_W'($urandom_range(0, 63));
      end else begin
         d.month  = MONTH_W'($urandom_range(1, 12));
         d.day    = DAY_W'($urandom_range(1, 31));
         d.hour   = HOUR_W'($urandom_range(0, 23));
         d.minute = MIN_W'($urandom_range(0, 59));
         d.second = SEC_W'($urandom_range(0, 59));
      end
      return d;
   endfunction

   task automatic flag_error(input string msg);
      error_count++;
      if (error_count <= MAX_REPORTS) $display("%s", msg);
   endtask

   // present one request and hold it until taken
   task automatic send_date(input date_req_type d);
      int unsigned gap;
      gap = 0;
      if (source_gaps_on && $urandom_range(0, 2) == 0)
         gap = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 30) : $urandom_range(1, 3);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid  <= 1'b1;
      req_year   <= d.year;
      req_month  <= d.month;
      req_day    <= d.day;
      req_hour   <= d.hour;
      req_minute <= d.minute;
      req_second <= d.second;
      do @(posedge clock); while (req_stall);
      epoch_queue.push_back(calendar_to_epoch(d));
      req_count++;
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (epoch_queue.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed_dates();
      date_req_type dates [22] = '{
         '{12'd1970, 4'd1,  5'd1,  5'd0,  6'd0,  6'd0},
         '{12'd2099, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59},
         '{12'd1969, 4'd6,  5'd15, 5'd12, 6'd0,  6'd0},
         '{12'd2100, 4'd1,  5'd1,  5'd0,  6'd0,  6'd0},
         '{12'd0,    4'd0,  5'd0,  5'd0,  6'd0,  6'd0},
         '{12'd4095, 4'd15, 5'd31, 5'd31, 6'd63, 6'd63},
         '{12'd1970, 4'd0,  5'd10, 5'd0,  6'd0,  6'd0},
         '{12'd2024, 4'd13, 5'd1,  5'd0,  6'd0,  6'd0},
         '{12'd2024, 4'd15, 5'd5,  5'd0,  6'd0,  6'd0},
         '{12'd1970, 4'd1,  5'd0,  5'd0,  6'd0,  6'd0},
         '{12'd1970, 4'd1,  5'd0,  5'd23, 6'd59, 6'd59},
         '{12'd2023, 4'd2,  5'd31, 5'd0,  6'd0,  6'd0},
         '{12'd2000, 4'd2,  5'd29, 5'd12, 6'd0,  6'd0},
         '{12'd2000, 4'd3,  5'd1,  5'd0,  6'd0,  6'd0},
         '{12'd1972, 4'd2,  5'd29, 5'd0,  6'd0,  6'd0},
         '{12'd1972, 4'd3,  5'd1,  5'd0,  6'd0,  6'd0},
         '{12'd2096, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59},
         '{12'd2099, 4'd12, 5'd31, 5'd31, 6'd63, 6'd63},
         '{12'd2038, 4'd1,  5'd19, 5'd3,  6'd14, 6'd8},
         '{12'd2099, 4'd15, 5'd31, 5'd31, 6'd63, 6'd63},
         '{12'd1980, 4'd6,  5'd15, 5'd0,  6'd0,  6'd0},
         '{12'd2001, 4'd3,  5'd1,  5'd0,  6'd0,  6'd0}
      };
      foreach (dates[i]) send_date(dates[i]);
      wait_idle();
   endtask

   // mostly well-formed dates; a few carry out-of-range fields
   task automatic test_random_dates();
      for (int i = 0; i < 1380; i++) begin
         if (i % 150 == 0) begin
            source_gaps_on = $urandom_range(0, 3) != 0;
            sink_stalls_on = $urandom_range(0, 3) != 0;
         end
         send_date(random_date(1'b0, $urandom_range(0, 9) == 0));
      end
      wait_idle();
   endtask

   task automatic test_wild_fields();
      for (int i = 0; i < 420; i++) begin
         if (i % 100 == 0) begin
            source_gaps_on = $urandom_range(0, 2) != 0;
            sink_stalls_on = $urandom_range(0, 2) != 0;
         end
         send_date(random_date($urandom_range(0, 1) == 0, 1'b1));
      end
      wait_idle();
   endtask

   // long receiver hold while requests keep coming, so the pipeline backs up
   task automatic test_response_hold();
      source_gaps_on = 1'b0;
      sink_hold_req = 1'b1;
      wait (sink_holding);
      for (int i = 0; i < 28; i++) send_date(random_date(1'b0, 1'b0));
      wait_idle();
   endtask

   initial begin : sink_stall_gen
      int unsigned n;
      forever begin
         @(negedge clock);
         if (sink_hold_req) begin
            sink_hold_req = 1'b0;
            sink_holding = 1'b1;
            rsp_stall <= 1'b1;
            repeat (SINK_HOLD_CYCLES - 1) @(negedge clock);
            sink_holding = 1'b0;
            hold_count++;
         end else if (sink_stalls_on && $urandom_range(0, 3) == 0) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
            rsp_stall <= 1'b1;
            repeat (n - 1) @(negedge clock);
         end else begin
            n = $urandom_range(1, 12);
            rsp_stall <= 1'b0;
            repeat (n - 1) @(negedge clock);
         end
      end
   end

   always @(posedge clock) begin : rsp_check
      epoch_rsp_type want;
      if (!reset && req_valid && req_stall) input_stall_cycles++;
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_count++;
         if (rsp_status) range_error_count++;
         if (epoch_queue.size() == 0) begin
            flag_error($sformatf("response %0d with nothing outstanding: epoch_seconds %0d status %0d",
                                 rsp_count, rsp_epoch_seconds, rsp_status));
         end else begin
            want = epoch_queue.pop_front();
            if (rsp_epoch_seconds !== want.secs)
               flag_error($sformatf("response %0d: epoch_seconds expected %0d, got %0d",
                                    rsp_count, want.secs, rsp_epoch_seconds));
            if (rsp_status !== want.status)
               flag_error($sformatf("response %0d: status expected %0d, got %0d",
                                    rsp_count, want.status, rsp_status));
         end
      end
   end

   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
         else quiet++;
      end
      $display("timeout: no handshake for %0d cycles, %0d responses outstanding",
               QUIET_LIMIT, epoch_queue.size());
      $display("date_to_epoch_seconds verification failed");
      $finish;
   end

   initial begin
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      test_directed_dates();
      test_random_dates();
      test_wild_fields();
      test_response_hold();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("covered %0d requests and %0d responses, %0d of them flagged for year range",
               req_count, rsp_count, range_error_count);
      $display("request side held off for %0d cycles, %0d long receiver holds, %0d mismatches",
               input_stall_cycles, hold_count, error_count);
      if (error_count == 0 && epoch_queue.size() == 0) begin
         $display("date_to_epoch_seconds verification clean");
      end else begin
         $display("date_to_epoch_seconds verification failed");
      end
      $finish;
   end

endmodule
